// ===== hdl/irdl_pkg.sv =====
// irdl_pkg: shared types, widths, register indexes and reset values for the
// ir distance linearizer. No dependencies.
`timescale 1ns / 1ps

package irdl_pkg;

  localparam int DEF_MAX_SAMPLES = 8;
  localparam int DEF_SAMPLE_BITS = 12;

  localparam int COUNT_W = 4;
  localparam int THR_W   = 12;
  localparam int CURVE_W = 22;
  localparam int DIST_W  = 11;
  localparam int LSTAT_W = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CURVE_W;

  localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT   = COUNT_W'(5);
  localparam logic [THR_W-1:0]   RST_THRESHOLD_MV   = THR_W'(420);
  localparam logic [CURVE_W-1:0] RST_CURVE_CONSTANT = CURVE_W'(278600);
  localparam logic [DIST_W-1:0]  RST_NEAR_LIMIT     = DIST_W'(100);
  localparam logic [DIST_W-1:0]  RST_FAR_LIMIT      = DIST_W'(800);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT   = 3'd0,
    REG_THRESHOLD_MV   = 3'd1,
    REG_CURVE_CONSTANT = 3'd2,
    REG_NEAR_LIMIT     = 3'd3,
    REG_FAR_LIMIT      = 3'd4
  } cfg_reg_t;

  localparam logic [LSTAT_W-1:0] LSTAT_IN_RANGE = 2'd0;
  localparam logic [LSTAT_W-1:0] LSTAT_NEAR     = 2'd1;
  localparam logic [LSTAT_W-1:0] LSTAT_FAR      = 2'd2;

  typedef struct packed {
    logic accept;
    logic calc;
    logic div_load;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic group_end;
    logic below;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hdl/irdl_ctrl.sv =====
// irdl_ctrl: sequencer for accumulate, offset, serial divide and clamp steps.
// Depends on irdl_pkg for the command and status structs.
`timescale 1ns / 1ps

module irdl_ctrl
  import irdl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CALC   = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (status.group_end) state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (status.below) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_load = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("finish did not publish a result");

  a_calc_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) |=> (state_r == S_CHECK))
    else $error("offset step not followed by check");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_done) |=> (state_r == S_FINISH))
    else $error("divider end missed");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && !out_free) |=> (state_r == S_FINISH && out_valid_r))
    else $error("pending result overwritten");

endmodule

// ===== hdl/irdl_dp.sv =====
// irdl_dp: configuration registers, sample accumulator, offset products,
// restoring serial divider and clamp/output registers. Depends on irdl_pkg.
`timescale 1ns / 1ps

module irdl_dp
  import irdl_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_BITS-1:0] sample_mv,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  output logic [DIST_W-1:0]     distance_tenths,
  output logic [LSTAT_W-1:0]    limit_status
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam int OFF_W  = THR_W + CNT_W;
  localparam int NUM_W  = CURVE_W + CNT_W;
  localparam int CMP_W  = (OFF_W > SUM_W) ? OFF_W : SUM_W;
  localparam int STEP_W = $clog2(NUM_W);

  logic [COUNT_W-1:0] count_cfg_r;
  logic [THR_W-1:0]   thr_r;
  logic [CURVE_W-1:0] curve_r;
  logic [DIST_W-1:0]  near_r;
  logic [DIST_W-1:0]  far_r;

  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W:0]     cnt_inc;

  logic [OFF_W-1:0]   off_r;
  logic [NUM_W-1:0]   num_r;
  logic [CMP_W-1:0]   diff;

  logic [NUM_W-1:0]   q_r;
  logic [SUM_W-1:0]   rem_r;
  logic [SUM_W-1:0]   den_r;
  logic [STEP_W-1:0]  step_r;
  logic [SUM_W:0]     rem_sh;
  logic [SUM_W:0]     rem_sub;
  logic               fits;

  logic [NUM_W-1:0]   value;
  logic [LSTAT_W-1:0] base_st;
  logic [DIST_W-1:0]  dist_nxt;
  logic [LSTAT_W-1:0] lstat_nxt;
  logic [DIST_W-1:0]  dist_r;
  logic [LSTAT_W-1:0] lstat_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_cfg_r <= RST_SAMPLE_COUNT;
      thr_r       <= RST_THRESHOLD_MV;
      curve_r     <= RST_CURVE_CONSTANT;
      near_r      <= RST_NEAR_LIMIT;
      far_r       <= RST_FAR_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_COUNT:   count_cfg_r <= cfg_data[COUNT_W-1:0];
        REG_THRESHOLD_MV:   thr_r       <= cfg_data[THR_W-1:0];
        REG_CURVE_CONSTANT: curve_r     <= cfg_data[CURVE_W-1:0];
        REG_NEAR_LIMIT:     near_r      <= cfg_data[DIST_W-1:0];
        REG_FAR_LIMIT:      far_r       <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // effective group size
  always_comb begin
    if (count_cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_cfg_r) > MAX_SAMPLES) begin
      n_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      n_eff = CNT_W'(count_cfg_r);
    end
  end

  assign cnt_inc = {1'b0, cnt_r} + (CNT_W + 1)'(1);

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (cmd.accept) begin
      sum_nxt = sum_r + SUM_W'(sample_mv);
      cnt_nxt = status.group_end ? '0 : cnt_inc[CNT_W-1:0];
    end else if (cmd.finish) begin
      sum_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // offset and numerator products
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      off_r <= OFF_W'(thr_r) * OFF_W'(n_eff);
      num_r <= NUM_W'(curve_r) * NUM_W'(n_eff);
    end
  end

  assign diff = CMP_W'(sum_r) - CMP_W'(off_r);

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_r, q_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r    <= num_r;
      rem_r  <= '0;
      den_r  <= diff[SUM_W-1:0];
      step_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[NUM_W-2:0], fits};
      rem_r  <= fits ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
  end

  // clamp
  always_comb begin
    value   = status.below ? NUM_W'(far_r) : q_r;
    base_st = status.below ? LSTAT_FAR : LSTAT_IN_RANGE;
    if (value < NUM_W'(near_r)) begin
      dist_nxt  = near_r;
      lstat_nxt = LSTAT_NEAR;
    end else if (value > NUM_W'(far_r)) begin
      dist_nxt  = far_r;
      lstat_nxt = LSTAT_FAR;
    end else begin
      dist_nxt  = value[DIST_W-1:0];
      lstat_nxt = base_st;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dist_r  <= dist_nxt;
      lstat_r <= lstat_nxt;
    end
  end

  assign status.group_end = (cnt_inc >= {1'b0, n_eff});
  assign status.below     = (CMP_W'(sum_r) <= CMP_W'(off_r));
  assign status.div_done  = (step_r == STEP_W'(NUM_W - 1));

  assign distance_tenths = dist_r;
  assign limit_status    = lstat_r;

endmodule

// ===== hdl/ir_distance_linearizer.sv =====
// ir_distance_linearizer: top level joining the controller and datapath.
// Depends on irdl_pkg, irdl_ctrl and irdl_dp.
//
//   group   dir   fields (low bit up)                      transfer when
//   in_     in    tdata: sample_mv                         tvalid && tready
//   out_    out   tdata: distance_tenths; tuser: status    tvalid && tready
//   cfg_    in    index / data write, no read-back         cfg_we
//
// a sample that does not end a group is accepted while idle; a group-ending
// sample goes on through the offset, check, restoring serial divide (one bit
// per cycle) and finish states, skipping the divide when at or below threshold.
// in_tready is high only while idle; a finished result waits in the output
// register while further samples accumulate, and the next group end stalls
// until that result is taken.
// synchronous active-low reset restores register defaults and clears the group.
`timescale 1ns / 1ps

module ir_distance_linearizer
  import irdl_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,  // sample_mv
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // distance_tenths
  output logic [LSTAT_W-1:0]    out_tuser    // limit_status
);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [DIST_W-1:0] distance_tenths;

  irdl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  irdl_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sample_mv       (in_tdata[SAMPLE_BITS-1:0]),
    .cmd             (cmd),
    .status          (status),
    .distance_tenths (distance_tenths),
    .limit_status    (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(distance_tenths);

endmodule
